// ----- src/hieq_pkg.sv -----
// Shared types and constants for the histogram equalizer.
package hieq_pkg;

    localparam int PIX_W   = 8;
    localparam int LEVEL_W = 8;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 1;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 8'd255;

    // Transaction kinds on the input channel
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_MAP   = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 1'b0;
    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 1'b1;

    // Commands from the table walker to the level unit
    typedef struct packed {
        logic init;
        logic add;
    } scale_ctrl_t;

    // Level unit status back to the walker
    typedef struct packed {
        logic               settled;
        logic [LEVEL_W-1:0] level;
    } scale_stat_t;

endpackage

// ----- src/histogram_equalizer.sv -----
// Histogram equalizer top level: histogram memory, mapping table and table walker.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   cfg      | in        | cfg_wr_en          | cfg_index, cfg_wdata
//   s        | in        | s_valid / s_ready  | s_req_type, s_pixel
//   m        | out       | m_valid / m_ready  | m_mapped_pixel
//
// Accumulate and map transactions are taken one per cycle while s_ready is high;
// a map result passes through the table read register and then an output register
// that frees the input side. The accumulate that completes a frame starts a table
// build (one bin read, add and level search per bin, at most 255 level steps in
// total), during which s_ready is low.
// After reset a clearing pass over the histogram runs while s_ready is low.
// A configuration write holds s_ready low for the following cycle.
module histogram_equalizer
    import hieq_pkg::*;
#(
    parameter int MAX_SIDE  = 256,
    parameter int BIN_COUNT = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [PIX_W-1:0]   s_pixel,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_mapped_pixel
);

    localparam longint MaxPix = longint'(MAX_SIDE) * longint'(MAX_SIDE);
    localparam int CNT_W  = $clog2(MaxPix + 1);
    localparam int NUM_W  = $clog2(MaxPix * 512 + 1);
    localparam int IDX_W  = $clog2(BIN_COUNT);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_WAIT,
        ST_READ,
        ST_ADD,
        ST_STEP
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    walk_reg;
    logic                built_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    n_reg;
    logic                cfg_lag_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [CFG_W-1:0]    width_reg;

    logic [CNT_W-1:0]    bin_mem [BIN_COUNT];
    logic [LEVEL_W-1:0]  map_mem [BIN_COUNT];
    logic [CNT_W-1:0]    bin_rd_reg;
    logic [LEVEL_W-1:0]  map_rd_reg;

    logic                acc1_vld_reg;
    logic [IDX_W-1:0]    acc1_idx_reg;
    logic                lastw_vld_reg;
    logic [IDX_W-1:0]    lastw_idx_reg;
    logic [CNT_W-1:0]    lastw_data_reg;

    logic                map1_vld_reg;
    logic                map1_zero_reg;
    logic                out_vld_reg;
    logic [LEVEL_W-1:0]  out_data_reg;

    logic [IDX_W-1:0]    s_idx;
    logic                s_fire;
    logic                acc_fire;
    logic                map_fire;
    logic                move;
    logic [CNT_W-1:0]    cnt_inc;
    logic                trigger;
    logic [CNT_W-1:0]    bin_base;
    logic [CNT_W-1:0]    bin_inc;
    logic [IDX_W-1:0]    bin_rd_addr;
    logic                bin_we;
    logic [IDX_W-1:0]    bin_wa;
    logic [CNT_W-1:0]    bin_wd;
    logic                map_we;
    logic                walk_last;
    logic [SIDE_W-1:0]   side_h;
    logic [SIDE_W-1:0]   side_w;
    logic [2*SIDE_W-1:0] side_prod;
    scale_ctrl_t         sc_ctrl;
    scale_stat_t         sc_stat;

    // Clamp one side register to 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return SIDE_W'(1);
        end else if (v32 > 32'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(v32);
    endfunction

    // Saturate a pixel to the last bin
    function automatic logic [IDX_W-1:0] pixel_bin(input logic [PIX_W-1:0] p);
        logic [31:0] p32;
        p32 = 32'(p);
        if (p32 >= 32'(BIN_COUNT)) begin
            return IDX_W'(BIN_COUNT - 1);
        end
        return IDX_W'(p32);
    endfunction

    // Input handshake and decode
    always_comb begin
        s_idx    = pixel_bin(s_pixel);
        move     = map1_vld_reg && (!out_vld_reg || m_ready);
        s_ready  = (state_reg == ST_RUN) && !cfg_lag_reg && (!map1_vld_reg || move);
        s_fire   = s_valid && s_ready;
        acc_fire = s_fire && (s_req_type == REQ_ACCUM);
        map_fire = s_fire && (s_req_type == REQ_MAP);
        cnt_inc  = cnt_reg + 1'b1;
        trigger  = acc_fire && (cnt_inc >= n_reg);
        walk_last = (walk_reg == IDX_W'(BIN_COUNT - 1));
    end

    // Frame size from the clamped sides
    always_comb begin
        side_h    = clamp_side(height_reg);
        side_w    = clamp_side(width_reg);
        side_prod = (2*SIDE_W)'(side_h) * (2*SIDE_W)'(side_w);
    end

    // Accumulate increment with forwarding from the previous histogram write
    always_comb begin
        if (lastw_vld_reg && (lastw_idx_reg == acc1_idx_reg)) begin
            bin_base = lastw_data_reg;
        end else begin
            bin_base = bin_rd_reg;
        end
        bin_inc = bin_base + 1'b1;
    end

    // Histogram port selection
    always_comb begin
        bin_rd_addr = (state_reg == ST_RUN) ? s_idx : walk_reg;
        bin_we      = 1'b0;
        bin_wa      = walk_reg;
        bin_wd      = '0;
        if (state_reg == ST_CLEAR || state_reg == ST_ADD) begin
            bin_we = 1'b1;
        end else if (acc1_vld_reg) begin
            bin_we = 1'b1;
            bin_wa = acc1_idx_reg;
            bin_wd = bin_inc;
        end
        map_we = (state_reg == ST_STEP) && sc_stat.settled;
    end

    // Level unit commands
    always_comb begin
        sc_ctrl.init = trigger;
        sc_ctrl.add  = (state_reg == ST_ADD);
    end

    hieq_scale #(
        .CNT_W (CNT_W),
        .NUM_W (NUM_W)
    ) u_scale (
        .aclk      (aclk),
        .ctrl      (sc_ctrl),
        .frame_n   (n_reg),
        .bin_count (bin_rd_reg),
        .stat      (sc_stat)
    );

    // Histogram memory
    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[bin_wa] <= bin_wd;
        end
        bin_rd_reg <= bin_mem[bin_rd_addr];
    end

    // Mapping table memory; read data holds while a map result waits
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[walk_reg] <= sc_stat.level;
        end
        if (map_fire) begin
            map_rd_reg <= map_mem[s_idx];
        end
    end

    // Payload registers of the accumulate and map paths
    always_ff @(posedge aclk) begin
        acc1_idx_reg   <= s_idx;
        lastw_idx_reg  <= acc1_idx_reg;
        lastw_data_reg <= bin_inc;
        if (map_fire) begin
            map1_zero_reg <= !built_reg;
        end
        if (move) begin
            out_data_reg <= map1_zero_reg ? '0 : map_rd_reg;
        end
        n_reg <= CNT_W'(side_prod);
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg  <= CFG_W'(256);
            width_reg   <= CFG_W'(256);
            cfg_lag_reg <= 1'b0;
        end else begin
            cfg_lag_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                    REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Handshake pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc1_vld_reg  <= 1'b0;
            lastw_vld_reg <= 1'b0;
            map1_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            acc1_vld_reg  <= acc_fire;
            lastw_vld_reg <= acc1_vld_reg;
            if (map_fire) begin
                map1_vld_reg <= 1'b1;
            end else if (move) begin
                map1_vld_reg <= 1'b0;
            end
            if (move) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Clearing pass, pixel count and table walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            walk_reg  <= '0;
            built_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (walk_last) begin
                        walk_reg  <= '0;
                        state_reg <= ST_RUN;
                    end else begin
                        walk_reg <= walk_reg + 1'b1;
                    end
                end
                ST_RUN: begin
                    if (trigger) begin
                        cnt_reg   <= '0;
                        walk_reg  <= '0;
                        state_reg <= ST_WAIT;
                    end else if (acc_fire) begin
                        cnt_reg <= cnt_inc;
                    end
                end
                ST_WAIT: begin
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    if (sc_stat.settled) begin
                        if (walk_last) begin
                            walk_reg  <= '0;
                            built_reg <= 1'b1;
                            state_reg <= ST_RUN;
                        end else begin
                            walk_reg  <= walk_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_mapped_pixel = out_data_reg;

endmodule

// ----- src/hieq_scale.sv -----
// Level unit: tracks the running sum and steps the rounded output level.
module hieq_scale
    import hieq_pkg::*;
#(
    parameter int CNT_W = 17,
    parameter int NUM_W = 26
) (
    input  logic             aclk,
    input  scale_ctrl_t      ctrl,
    input  logic [CNT_W-1:0] frame_n,
    input  logic [CNT_W-1:0] bin_count,
    output scale_stat_t      stat
);

    // num = 2*255*sum + N; thr = 2*N*(level+1)
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   thr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [NUM_W-1:0]   n_ext;
    logic [NUM_W-1:0]   cnt_ext;
    logic [NUM_W-1:0]   scaled;
    logic               can_step;

    // 510 * count as a shift and subtract
    always_comb begin
        n_ext    = NUM_W'(frame_n);
        cnt_ext  = NUM_W'(bin_count);
        scaled   = (cnt_ext << 9) - (cnt_ext << 1);
        can_step = (level_reg != MAX_LEVEL) && (num_reg >= thr_reg);
    end

    assign stat.settled = !can_step;
    assign stat.level   = level_reg;

    // Load, accumulate, or advance the level by one
    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            num_reg   <= n_ext;
            thr_reg   <= n_ext << 1;
            level_reg <= '0;
        end else if (ctrl.add) begin
            num_reg <= num_reg + scaled;
        end else if (can_step) begin
            level_reg <= level_reg + 1'b1;
            thr_reg   <= thr_reg + (n_ext << 1);
        end
    end

endmodule
